@@ rtl/core/fnv1a_distinct_key_counter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the distinct key counter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FNV1A_DISTINCT_KEY_COUNTER_TOP_MACROS_SVH
`define FNV1A_DISTINCT_KEY_COUNTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FDKC_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("fdkc check failed");
// next-cycle implication
`define FDKC_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("fdkc check failed");
`else
`define FDKC_ASSERT_NOW(label, clk, rst, cond, expr)
`define FDKC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

@@ rtl/core/fdkc_pkg.sv @@
// ----------------------------------------------------------------------------
// fdkc_pkg
// Constants shared by the distinct key counter modules.
// ----------------------------------------------------------------------------
package fdkc_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] HASH_ONE  = 32'd1;

  localparam logic [5:0] COUNT_MAX = 6'd63;

  localparam logic [1:0] OUT_SEEN   = 2'd0;
  localparam logic [1:0] OUT_STORED = 2'd1;
  localparam logic [1:0] OUT_FULL   = 2'd2;

endpackage

@@ rtl/core/fdkc_in_if.sv @@
// ----------------------------------------------------------------------------
// fdkc_in_if
// Key byte request channel.
// ----------------------------------------------------------------------------
interface fdkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       key_last;
  logic       empty_key;

  modport source (output valid, output key_byte, output key_last, output empty_key,
                  input ready);
  modport sink (input valid, input key_byte, input key_last, input empty_key,
                output ready);
endinterface

@@ rtl/core/fdkc_out_if.sv @@
// ----------------------------------------------------------------------------
// fdkc_out_if
// Probe result channel.
// ----------------------------------------------------------------------------
interface fdkc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [31:0] key_hash;
  logic [5:0]  distinct_count;

  modport source (output valid, output outcome, output key_hash, output distinct_count,
                  input ready);
  modport sink (input valid, input outcome, input key_hash, input distinct_count,
                output ready);
endinterface

@@ rtl/core/fdkc_hash_unit.sv @@
// ----------------------------------------------------------------------------
// fdkc_hash_unit
// Registered FNV-1a multiply: product = operand * prime mod 2^32.
// ----------------------------------------------------------------------------
module fdkc_hash_unit (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] operand,
  output logic [31:0] product
);
  import fdkc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      product <= operand * FNV_PRIME;
    end
  end
endmodule

@@ rtl/core/fdkc_slot_table.sv @@
// ----------------------------------------------------------------------------
// fdkc_slot_table
// Hash slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fdkc_slot_table #(
  parameter int TABLE_ENTRIES = fdkc_pkg::TABLE_ENTRIES_DEF,
  parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);
  import fdkc_pkg::*;

  logic [31:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end
endmodule

@@ rtl/core/fnv1a_distinct_key_counter_top.sv @@
// ----------------------------------------------------------------------------
// fnv1a_distinct_key_counter_top
// Counts distinct keys by FNV-1a hash in a small insert-only hash set.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one key byte per request, with key_last on the final byte,
//   or empty_key for a key with no bytes. out_ch gives one result per key:
//   outcome, the key hash (zero remapped to one) and the distinct count.
//   Requests are taken one at a time; in_ch.ready is high only while idle.
//   A byte that is not last passes through accept, multiply and fold. A
//   last byte then probes the filled slots in order, ends on a match, at
//   the first empty slot (a miss) or on a full table, and then loads the
//   result register; an empty key skips the multiply and fold. The probe
//   walks the slot memory one entry at a time (read, then compare) through
//   one registered read port. Slots fill in order and are never freed, so a
//   fill count marks the empty slots and no clearing pass is needed after
//   reset.
//   Reset empties the table, zeroes the count and restores the offset basis.
//   A result waits in the output register while out_ch.ready is low; the next
//   key request is still accepted and processed, and its result waits until
//   the register frees.
// ----------------------------------------------------------------------------
`include "fnv1a_distinct_key_counter_top_macros.svh"

module fnv1a_distinct_key_counter_top #(
  parameter int TABLE_ENTRIES = fdkc_pkg::TABLE_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst,
  fdkc_in_if.sink    in_ch,
  fdkc_out_if.source out_ch
);
  import fdkc_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int IW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] FULL_FILL = IW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_FOLD, ST_SCAN, ST_CMP, ST_FINISH
  } state_t;

  state_t        state;
  logic [31:0]   running_hash;
  logic [31:0]   mul_operand;
  logic          last_byte;
  logic [31:0]   probe_hash;
  logic [IW-1:0] idx;
  logic [IW-1:0] fill;
  logic [5:0]    stored_count;
  logic [1:0]    result_code;

  logic          accept;
  logic          mul_en;
  logic [31:0]   product;
  logic          wr_en;
  logic [31:0]   rd_data;
  logic          out_free;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign mul_en      = (state == ST_MUL);
  assign wr_en       = (state == ST_SCAN) && (idx == fill) && (fill != FULL_FILL);
  assign out_free    = !out_ch.valid || out_ch.ready;

  fdkc_hash_unit u_hash (
    .clk     (clk),
    .en      (mul_en),
    .operand (mul_operand),
    .product (product)
  );

  fdkc_slot_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx[AW-1:0]),
    .wr_data (probe_hash),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_hash <= FNV_BASIS;
      fill         <= '0;
      stored_count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if ((state == ST_FINISH) && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.empty_key) begin
              // drop any partial key and probe the empty-key hash
              running_hash <= FNV_BASIS;
              probe_hash   <= FNV_BASIS;
              idx          <= '0;
              state        <= ST_SCAN;
            end else begin
              mul_operand <= running_hash ^ {24'd0, in_ch.key_byte};
              last_byte   <= in_ch.key_last;
              state       <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_FOLD;
        end
        ST_FOLD: begin
          if (last_byte) begin
            probe_hash   <= (product == 32'd0) ? HASH_ONE : product;
            running_hash <= FNV_BASIS;
            idx          <= '0;
            state        <= ST_SCAN;
          end else begin
            running_hash <= product;
            state        <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (idx == fill) begin
            if (fill == FULL_FILL) begin
              result_code <= OUT_FULL;
            end else begin
              fill        <= fill + 1'b1;
              result_code <= OUT_STORED;
              if (stored_count != COUNT_MAX) begin
                stored_count <= stored_count + 1'b1;
              end
            end
            state <= ST_FINISH;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (rd_data == probe_hash) begin
            result_code <= OUT_SEEN;
            state       <= ST_FINISH;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_ch.outcome        <= result_code;
            out_ch.key_hash       <= probe_hash;
            out_ch.distinct_count <= stored_count;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FDKC_ASSERT_NOW(a_write_not_full, clk, rst, wr_en, fill < FULL_FILL)
  `FDKC_ASSERT_NOW(a_cmp_in_filled, clk, rst, state == ST_CMP, idx < fill)
  `FDKC_ASSERT_NEXT(a_fill_advances, clk, rst, wr_en, fill == $past(fill) + 1'b1)
  `FDKC_ASSERT_NEXT(a_finish_delivers, clk, rst, (state == ST_FINISH) && out_free, out_ch.valid && (state == ST_IDLE))

endmodule
